FILE: hdl/mmpt_pkg.sv
// Shared constants and types for the Markov miss prefetch table.
package mmpt_pkg;
   localparam int ROWS       = 1024;
   localparam int SUCCESSORS = 8;
   localparam int ADDR_BITS  = 48;
   localparam int COUNT_BITS = 16;
   localparam int ROW_BITS   = $clog2(ROWS);
   localparam int SLOT_BITS  = $clog2(SUCCESSORS);
   localparam int SUCC_DEPTH = ROWS * SUCCESSORS;
   localparam int SUCC_BITS  = $clog2(SUCC_DEPTH);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [ROW_BITS-1:0]   row_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE,
      ST_LRN_RD, ST_LRN_SCAN, ST_LRN_LOW, ST_LRN_WR,
      ST_ROW_RD, ST_ROW_SCAN, ST_ROW_WR,
      ST_WIPE, ST_PRD_RD, ST_PRD_SCAN, ST_DONE
   } state_type;

   function automatic count_type sat_inc(input count_type c);
      return (c == COUNT_MAX) ? c : c + count_type'(1);
   endfunction
endpackage

FILE: hdl/markov_miss_prefetch_table.sv
// Top level of the Markov miss prefetch table: sequencer over row and slot memories.
// Steps per miss: learn pass over the previous row's slots (if any), tag scan over
// all rows, slot wipe on a new row, prediction scan over the row's slots, result.
// Throughput: one miss at a time; busy is high from accept through rsp_valid.
// Reset: synchronous; after reset a clearing pass over all ROWS*SUCCESSORS slot
// entries zeroes both memories, with busy high. The receiver cannot stall.
module markov_miss_prefetch_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [mmpt_pkg::ADDR_BITS-1:0] req_miss_addr,
   output logic                          rsp_valid,
   output logic [47:0]                   rsp_prefetch_addr,
   output logic                          rsp_prefetch_valid
);
   import mmpt_pkg::*;

   // row memory: tag + use count; slot memory: addr + count
   logic [ADDR_BITS+COUNT_BITS-1:0] row_mem  [ROWS];
   logic [ADDR_BITS+COUNT_BITS-1:0] succ_mem [SUCC_DEPTH];

   state_type state_ff, state_in;
   addr_type  addr_ff, addr_in;
   row_type   prev_row_ff, prev_row_in;
   logic      prev_vld_ff, prev_vld_in;
   logic [SUCC_BITS:0] cnt_ff, cnt_in;      // scan index, one spare bit for end
   logic      hit_ff, hit_in;               // match found in scan
   logic [SUCC_BITS-1:0] sel_ff, sel_in;    // matched/lowest/highest index
   count_type best_ff, best_in;             // count at sel
   count_type hitc_ff, hitc_in;             // count of match
   row_type   row_ff, row_in;               // current row
   logic      rd_first_ff, rd_first_in;

   // memory ports
   logic row_rd, row_we, sc_rd, sc_we;
   row_type row_ra, row_wa;
   logic [SUCC_BITS-1:0] sc_ra, sc_wa;
   logic [ADDR_BITS+COUNT_BITS-1:0] row_wd, sc_wd, row_q, sc_q;
   logic [SUCC_BITS-1:0] idx_q_ff;          // index of the registered read data

   always_ff @(posedge clock) begin
      if (row_we) row_mem[row_wa] <= row_wd;
      if (row_rd) row_q <= row_mem[row_ra];
      if (sc_we) succ_mem[sc_wa] <= sc_wd;
      if (sc_rd) sc_q <= succ_mem[sc_ra];
   end

   addr_type  q_addr;
   count_type q_cnt;
   logic      last_rd;
   always_comb begin
      q_addr = (state_ff == ST_ROW_SCAN) ? row_q[ADDR_BITS+COUNT_BITS-1:COUNT_BITS]
                                         : sc_q[ADDR_BITS+COUNT_BITS-1:COUNT_BITS];
      q_cnt  = (state_ff == ST_ROW_SCAN) ? row_q[COUNT_BITS-1:0] : sc_q[COUNT_BITS-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      last_rd = 1'b0;
      case (state_ff)
         ST_CLEAR:    if (cnt_ff == (SUCC_BITS+1)'(SUCC_DEPTH-1)) state_in = ST_IDLE;
         ST_IDLE:     if (start) state_in = prev_vld_ff ? ST_LRN_RD : ST_ROW_RD;
         ST_LRN_RD:   state_in = ST_LRN_SCAN;
         ST_LRN_SCAN: begin
            last_rd = (cnt_ff == (SUCC_BITS+1)'(SUCCESSORS));
            if (last_rd) state_in = ST_LRN_WR;
         end
         ST_LRN_LOW:  state_in = ST_LRN_WR;
         ST_LRN_WR:   state_in = ST_ROW_RD;
         ST_ROW_RD:   state_in = ST_ROW_SCAN;
         ST_ROW_SCAN: begin
            last_rd = (cnt_ff == (SUCC_BITS+1)'(ROWS));
            if (last_rd) state_in = ST_ROW_WR;
         end
         ST_ROW_WR:   state_in = hit_ff ? ST_PRD_RD : ST_WIPE;
         ST_WIPE:     if (cnt_ff == (SUCC_BITS+1)'(SUCCESSORS-1)) state_in = ST_PRD_RD;
         ST_PRD_RD:   state_in = ST_PRD_SCAN;
         ST_PRD_SCAN: begin
            last_rd = (cnt_ff == (SUCC_BITS+1)'(SUCCESSORS));
            if (last_rd) state_in = ST_DONE;
         end
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   logic [SUCC_BITS-1:0] base;
   logic [SUCC_BITS-1:0] pbase;
   assign base  = SUCC_BITS'(row_ff) << SLOT_BITS;
   assign pbase = SUCC_BITS'(prev_row_ff) << SLOT_BITS;

   // datapath and memory control
   always_comb begin
      addr_in = addr_ff; prev_row_in = prev_row_ff; prev_vld_in = prev_vld_ff;
      cnt_in = cnt_ff; hit_in = hit_ff; sel_in = sel_ff; best_in = best_ff;
      hitc_in = hitc_ff; row_in = row_ff; rd_first_in = rd_first_ff;
      row_rd = 1'b0; row_we = 1'b0; sc_rd = 1'b0; sc_we = 1'b0;
      row_ra = '0; row_wa = '0; sc_ra = '0; sc_wa = '0;
      row_wd = '0; sc_wd = '0;
      case (state_ff)
         ST_CLEAR: begin
            sc_we = 1'b1; sc_wa = cnt_ff[SUCC_BITS-1:0];
            row_we = 1'b1; row_wa = cnt_ff[ROW_BITS-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (state_in == ST_IDLE) cnt_in = '0;
         end
         ST_IDLE: begin
            addr_in = req_miss_addr; cnt_in = '0; hit_in = 1'b0; rd_first_in = 1'b1;
         end
         ST_LRN_RD, ST_PRD_RD: begin
            sc_rd = 1'b1;
            sc_ra = (state_ff == ST_LRN_RD) ? pbase : base;
            cnt_in = (SUCC_BITS+1)'(1);
            rd_first_in = 1'b1;
         end
         ST_ROW_RD: begin
            row_rd = 1'b1; row_ra = '0; cnt_in = (SUCC_BITS+1)'(1); hit_in = 1'b0;
            rd_first_in = 1'b1;
         end
         ST_LRN_SCAN, ST_PRD_SCAN: begin
            if (!last_rd) begin
               sc_rd = 1'b1;
               sc_ra = ((state_ff == ST_LRN_SCAN) ? pbase : base)
                       | SUCC_BITS'(cnt_ff[SLOT_BITS-1:0]);
            end
            cnt_in = cnt_ff + 1'b1;
            rd_first_in = 1'b0;
            if (state_ff == ST_LRN_SCAN) begin
               if (!hit_ff && q_addr == addr_ff) begin
                  hit_in = 1'b1; hitc_in = q_cnt; sel_in = idx_q_ff;
               end else if (!hit_ff && (rd_first_ff || q_cnt <= best_ff)) begin
                  sel_in = idx_q_ff; best_in = q_cnt;
               end
            end else if (rd_first_ff || q_cnt >= best_ff) begin
               sel_in = idx_q_ff; best_in = q_cnt; addr_in = q_addr;
            end
            if (last_rd) cnt_in = '0;
         end
         ST_LRN_LOW: ;
         ST_LRN_WR: begin
            sc_we = 1'b1;
            sc_wa = pbase | SUCC_BITS'(sel_ff[SLOT_BITS-1:0]);
            sc_wd = hit_ff ? {addr_ff, sat_inc(hitc_ff)} : {addr_ff, count_type'(0)};
            hit_in = 1'b0;
         end
         ST_ROW_SCAN: begin
            if (!last_rd) begin
               row_rd = 1'b1; row_ra = cnt_ff[ROW_BITS-1:0];
            end
            cnt_in = cnt_ff + 1'b1;
            rd_first_in = 1'b0;
            if (!hit_ff && q_addr == addr_ff) begin
               hit_in = 1'b1; hitc_in = q_cnt; sel_in = idx_q_ff;
            end else if (!hit_ff && (rd_first_ff || q_cnt <= best_ff)) begin
               sel_in = idx_q_ff; best_in = q_cnt;
            end
            if (last_rd) cnt_in = '0;
         end
         ST_ROW_WR: begin
            row_we = 1'b1; row_wa = sel_ff[ROW_BITS-1:0];
            row_in = sel_ff[ROW_BITS-1:0];
            row_wd = hit_ff ? {addr_ff, sat_inc(hitc_ff)} : {addr_ff, count_type'(0)};
            prev_row_in = sel_ff[ROW_BITS-1:0]; prev_vld_in = 1'b1;
            cnt_in = '0;
         end
         ST_WIPE: begin
            sc_we = 1'b1;
            sc_wa = base | SUCC_BITS'(cnt_ff[SLOT_BITS-1:0]);
            cnt_in = cnt_ff + 1'b1;
            if (state_in == ST_PRD_RD) cnt_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; cnt_ff <= '0; prev_vld_ff <= 1'b0;
         prev_row_ff <= '0; hit_ff <= 1'b0; rd_first_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; prev_vld_ff <= prev_vld_in;
         prev_row_ff <= prev_row_in; hit_ff <= hit_in; rd_first_ff <= rd_first_in;
      end
      addr_ff <= addr_in; sel_ff <= sel_in; best_ff <= best_in;
      hitc_ff <= hitc_in; row_ff <= row_in;
      // first read of a scan is entry 0, later reads follow the scan index
      idx_q_ff <= (state_ff == ST_LRN_RD || state_ff == ST_PRD_RD ||
                   state_ff == ST_ROW_RD) ? '0 : cnt_ff[SUCC_BITS-1:0];
   end

   // result: addr_ff holds the highest-count slot address after the prediction scan
   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = (state_ff == ST_DONE);
   assign rsp_prefetch_addr  = 48'(addr_ff);
   assign rsp_prefetch_valid = (48'(addr_ff) != 48'd0);
endmodule

FILE: hdl/mmpt_checker.sv
// Port-level checks for the Markov miss prefetch table, bound to the top level.
module mmpt_props (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic [47:0] rsp_prefetch_addr,
   input logic rsp_prefetch_valid
);
   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_prefetch_valid == (rsp_prefetch_addr != 48'd0)))
      else $error("prefetch_valid disagrees with address");
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not raise busy");
endmodule

bind markov_miss_prefetch_table mmpt_props u_chk (.*);

FILE: sim/mmpt_checker.sv
// Checker for the Markov miss prefetch table: watches transfers, predicts, compares.
`timescale 1ns / 1ps
module mmpt_checker
   import mmpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  addr_type    req_miss_addr,
   input  logic        rsp_valid,
   input  logic [47:0] rsp_prefetch_addr,
   input  logic        rsp_prefetch_valid,
   output int          fail_count,
   output int          pending_count
);
   typedef struct packed {
      logic [47:0] addr;
      logic        valid;
   } prefetch_type;

   addr_type     tag_mem [ROWS];
   count_type    row_hits [ROWS];
   addr_type     next_addr [SUCC_DEPTH];
   count_type    next_hits [SUCC_DEPTH];
   row_type      last_row;
   logic         last_row_known;
   prefetch_type expected_prefetches[$];

   function automatic count_type bump(input count_type c);
      return (c == COUNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic prefetch_type predict_prefetch(input addr_type a);
      int base;
      int low;
      int hit;
      int row;
      int top;
      prefetch_type p;
      if (last_row_known) begin
         base = int'(last_row) * SUCCESSORS;
         hit = -1;
         for (int s = 0; s < SUCCESSORS; s++)
            if (hit < 0 && next_addr[base+s] == a) hit = s;
         if (hit >= 0) begin
            next_hits[base+hit] = bump(next_hits[base+hit]);
         end else begin
            low = 0;
            for (int s = 1; s < SUCCESSORS; s++)
               if (next_hits[base+s] <= next_hits[base+low]) low = s;
            next_addr[base+low] = a;
            next_hits[base+low] = '0;
         end
      end
      row = -1;
      for (int r = 0; r < ROWS; r++)
         if (row < 0 && tag_mem[r] == a) row = r;
      if (row >= 0) begin
         row_hits[row] = bump(row_hits[row]);
      end else begin
         row = 0;
         for (int r = 1; r < ROWS; r++)
            if (row_hits[r] <= row_hits[row]) row = r;
         tag_mem[row] = a;
         row_hits[row] = '0;
         for (int s = 0; s < SUCCESSORS; s++) begin
            next_addr[row*SUCCESSORS+s] = '0;
            next_hits[row*SUCCESSORS+s] = '0;
         end
      end
      last_row = row_type'(row);
      last_row_known = 1'b1;
      base = row * SUCCESSORS;
      top = 0;
      for (int s = 1; s < SUCCESSORS; s++)
         if (next_hits[base+s] >= next_hits[base+top]) top = s;
      p.addr = next_addr[base+top][47:0];
      p.valid = (p.addr != 0);
      return p;
   endfunction

   assign pending_count = expected_prefetches.size();

   initial begin
      fail_count = 0;
      for (int r = 0; r < ROWS; r++) begin
         tag_mem[r] = '0;
         row_hits[r] = '0;
      end
      for (int i = 0; i < SUCC_DEPTH; i++) begin
         next_addr[i] = '0;
         next_hits[i] = '0;
      end
      last_row = '0;
      last_row_known = 1'b0;
   end

   always @(posedge clock) begin
      prefetch_type want;
      if (!reset) begin
         if (start && !busy)
            expected_prefetches.push_back(predict_prefetch(req_miss_addr));
         if (rsp_valid) begin
            if (expected_prefetches.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: addr %h valid %b",
                           rsp_prefetch_addr, rsp_prefetch_valid);
            end else begin
               want = expected_prefetches.pop_front();
               if (want.addr !== rsp_prefetch_addr || want.valid !== rsp_prefetch_valid) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected addr %h valid %b, got addr %h valid %b",
                              want.addr, want.valid, rsp_prefetch_addr, rsp_prefetch_valid);
               end
            end
         end
      end
   end
endmodule

FILE: sim/markov_miss_prefetch_table_tb.sv
// Testbench top for the Markov miss prefetch table: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module markov_miss_prefetch_table_tb;
   import mmpt_pkg::*;

   localparam int RANDOM_MISSES = 550;
   localparam int STALL_LIMIT   = 40000;  // covers the clearing pass and the longest miss

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   addr_type    req_miss_addr = '0;
   logic        rsp_valid;
   logic [47:0] rsp_prefetch_addr;
   logic        rsp_prefetch_valid;
   int          fail_count;
   int          pending_count;
   int          quiet_cycles = 0;
   int          idle_pct = 0;  // chance per cycle that the sender sits idle
   addr_type    hot_addrs[16];

   always #6 clock = ~clock;

   markov_miss_prefetch_table uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_miss_addr(req_miss_addr), .rsp_valid(rsp_valid),
      .rsp_prefetch_addr(rsp_prefetch_addr), .rsp_prefetch_valid(rsp_prefetch_valid)
   );

   mmpt_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_miss_addr(req_miss_addr), .rsp_valid(rsp_valid),
      .rsp_prefetch_addr(rsp_prefetch_addr), .rsp_prefetch_valid(rsp_prefetch_valid),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Watchdog: any stretch with no transfer on either side is bounded.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic addr_type random_addr();
      return addr_type'({$urandom, $urandom});
   endfunction

   // One miss transfer; start stays high across back-to-back misses.
   task automatic send_miss(input addr_type a);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_miss_addr <= a;
      do @(posedge clock); while (busy);
   endtask

   // Hold off until every outstanding prediction has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      addr_type a;
      addr_type b;
      int pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 16; i++) hot_addrs[i] = random_addr();
      hot_addrs[0] = '0;
      hot_addrs[1] = '1;

      // Directed: address zero against cleared rows, extremes, single bits,
      // a repeated A-B chain so the learned successor wins.
      send_miss('0);
      send_miss('0);
      send_miss('1);
      send_miss('0);
      send_miss('1);
      send_miss('0);
      for (int i = 0; i < ADDR_BITS; i += 6) send_miss(addr_type'(1) << i);
      a = 48'h5555_aaaa_5555;
      b = 48'haaaa_5555_aaaa;
      for (int i = 0; i < 5; i++) begin
         send_miss(a);
         send_miss(b);
      end
      drain();

      // Random: mostly replayed chains over a small hot set so rows and
      // slots build up counts, with fresh addresses as noise.
      for (int i = 0; i < RANDOM_MISSES; i++) begin
         case (i * 4 / RANDOM_MISSES)
            0: idle_pct = 0;
            1: idle_pct = 53;
            2: idle_pct = 8;
            default: idle_pct = 0;
         endcase
         if (i == RANDOM_MISSES / 2) drain();
         pick = $urandom_range(99);
         if (pick < 70)
            send_miss(hot_addrs[(i + $urandom_range(1)) % 16]);
         else if (pick < 85)
            send_miss(hot_addrs[$urandom_range(15)]);
         else
            send_miss(random_addr());
      end

      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
